@@ sv/aqt_pkg.sv @@
// aqt_pkg: shared types and constants of the ack quorum tracker.
// No dependencies; used by every module of the block.
package aqt_pkg;

   localparam int AQT_SLOTS  = 8;
   localparam int AQT_WAIT_W = 4;
   localparam int AQT_SID_W  = 32;
   localparam int AQT_POS_W  = 64;

   localparam logic [AQT_WAIT_W-1:0] AQT_WAIT_RESET  = 4'd1;
   localparam logic [AQT_WAIT_W-1:0] AQT_WAIT_DIRECT = 4'd1;
   localparam logic [AQT_WAIT_W-1:0] AQT_WAIT_NONE   = 4'd0;

   localparam logic AQT_FUNC_ACK   = 1'b0;
   localparam logic AQT_FUNC_CLEAR = 1'b1;

   typedef struct packed {
      logic                 func;
      logic [AQT_SID_W-1:0] replica_id;
      logic [AQT_POS_W-1:0] log_pos;
   } req_type;

   typedef struct packed {
      logic                 quorum_reached;
      logic [AQT_POS_W-1:0] quorum_pos;
      logic [AQT_SID_W-1:0] quorum_server;
   } rsp_type;

   typedef struct packed {
      logic [AQT_SID_W-1:0] server;
      logic [AQT_POS_W-1:0] position;
   } entry_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic wr_free;
      logic clr;
   } mem_ctl_type;

endpackage

@@ sv/ack_quorum_tracker_core.sv @@
// ack_quorum_tracker_core: top level; wait_count register, result register,
// sequencer and slot memory. Depends on aqt_pkg, aqt_seq, aqt_slot_mem.
//
// One request at a time. A clear, a direct-mode ack (wait_count 1), a stale ack
// or an ack with server id 0 goes from idle straight to the done state. A table
// ack walks the slot memory one entry per cycle through its single read port,
// over n = min(wait_count-1, SLOTS) entries: a find pass, and when a quorum is
// reported also a minimum pass and a free pass. The result sits in an output
// register, so the next request is taken while it waits. Writing a nonzero
// wait_count frees all slots at once; a write of zero is ignored.
module ack_quorum_tracker_core import aqt_pkg::*; #(
   parameter int SLOTS = AQT_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wen,
   input  logic [AQT_WAIT_W-1:0] csr_wdata
);

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);

   logic [AQT_WAIT_W-1:0] wait_count_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;
   logic                  csr_clr;
   logic                  res_valid;
   logic                  res_ready;
   rsp_type               res_data;
   mem_ctl_type           seq_ctl;
   mem_ctl_type           mem_ctl;
   logic [AW-1:0]         mem_rd_addr;
   logic [AW-1:0]         mem_wr_addr;
   entry_type             mem_wr_data;
   entry_type             rd_entry;

   assign csr_clr = csr_wen && (csr_wdata != AQT_WAIT_NONE);

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_count_ff <= AQT_WAIT_RESET;
      end else if (csr_clr) begin
         wait_count_ff <= csr_wdata;
      end
   end

   always_comb begin
      mem_ctl     = seq_ctl;
      mem_ctl.clr = seq_ctl.clr || csr_clr;
   end

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   aqt_seq #(
      .SLOTS (SLOTS),
      .AW    (AW),
      .CW    (CW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .wait_count  (wait_count_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .mem_ctl     (seq_ctl),
      .mem_rd_addr (mem_rd_addr),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .rd_entry    (rd_entry)
   );

   aqt_slot_mem #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (mem_ctl),
      .rd_addr  (mem_rd_addr),
      .wr_addr  (mem_wr_addr),
      .wr_data  (mem_wr_data),
      .rd_entry (rd_entry)
   );

endmodule

@@ sv/aqt_slot_mem.sv @@
// aqt_slot_mem: slot table memory, one read and one write port, registered read.
// Per-entry valid bits give free slots after reset or clear. Depends on aqt_pkg.
module aqt_slot_mem import aqt_pkg::*; #(
   parameter int SLOTS = AQT_SLOTS,
   parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  mem_ctl_type   ctl,
   input  logic [AW-1:0] rd_addr,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   output entry_type     rd_entry
);

   entry_type          mem_q [SLOTS];
   entry_type          rd_data_ff;
   logic               rd_ok_ff;
   logic [SLOTS-1:0]   valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en && !ctl.wr_free) begin
         mem_q[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_q[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         valid_ff <= '0;
      end else if (ctl.wr_en) begin
         valid_ff[wr_addr] <= !ctl.wr_free;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ok_ff <= 1'b0;
      end else if (ctl.rd_en) begin
         rd_ok_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_entry = rd_ok_ff ? rd_data_ff : '0;

endmodule

@@ sv/aqt_seq.sv @@
// aqt_seq: request sequencer; scans the slot table (find, minimum, free passes)
// and produces one result per request. Depends on aqt_pkg, drives aqt_slot_mem.
module aqt_seq import aqt_pkg::*; #(
   parameter int SLOTS = AQT_SLOTS,
   parameter int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1,
   parameter int CW    = $clog2(SLOTS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic [AQT_WAIT_W-1:0] wait_count,
   output logic                  res_valid,
   input  logic                  res_ready,
   output rsp_type               res_data,
   output mem_ctl_type           mem_ctl,
   output logic [AW-1:0]         mem_rd_addr,
   output logic [AW-1:0]         mem_wr_addr,
   output entry_type             mem_wr_data,
   input  entry_type             rd_entry
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_FIND = 5'b00010,
      S_MIN  = 5'b00100,
      S_FREE = 5'b01000,
      S_DONE = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [AQT_SID_W-1:0]  cur_sid_ff, cur_sid_in;
   logic [AQT_POS_W-1:0]  cur_pos_ff, cur_pos_in;
   logic [AQT_POS_W-1:0]  last_pos_ff, last_pos_in;
   logic [AQT_SID_W-1:0]  last_srv_ff, last_srv_in;
   logic [CW-1:0]         addr_ff, addr_in;
   logic                  rd_act_ff, rd_act_in;
   logic [AW-1:0]         rd_idx_ff, rd_idx_in;
   logic                  mark_ff, mark_in;
   logic [AW-1:0]         mark_idx_ff, mark_idx_in;
   logic                  hit_ff, hit_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   logic                  raise_ff, raise_in;
   logic [AQT_POS_W-1:0]  min_pos_ff, min_pos_in;
   logic [AQT_SID_W-1:0]  min_srv_ff, min_srv_in;
   rsp_type               res_ff, res_in;

   logic [AQT_WAIT_W-1:0] wc_m1;
   logic [CW-1:0]         n_act;
   logic                  scanning;
   logic                  scan_done;

   // active slot count: wait_count - 1, capped at SLOTS
   always_comb begin
      wc_m1 = wait_count - AQT_WAIT_DIRECT;
      if (32'(wc_m1) > SLOTS) begin
         n_act = CW'(SLOTS);
      end else begin
         n_act = CW'(wc_m1);
      end
   end

   assign scanning  = (state_ff == S_FIND) || (state_ff == S_MIN) || (state_ff == S_FREE);
   assign scan_done = (addr_ff == n_act) && !rd_act_ff;

   always_comb begin
      state_in    = state_ff;
      cur_sid_in  = cur_sid_ff;
      cur_pos_in  = cur_pos_ff;
      last_pos_in = last_pos_ff;
      last_srv_in = last_srv_ff;
      addr_in     = addr_ff;
      rd_act_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      mark_in     = mark_ff;
      mark_idx_in = mark_idx_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      raise_in    = raise_ff;
      min_pos_in  = min_pos_ff;
      min_srv_in  = min_srv_ff;
      res_in      = res_ff;
      mem_ctl     = '0;
      mem_rd_addr = addr_ff[AW-1:0];
      mem_wr_addr = '0;
      mem_wr_data = '0;
      req_ready   = 1'b0;
      res_valid   = 1'b0;

      if (scanning && (addr_ff != n_act)) begin
         mem_ctl.rd_en = 1'b1;
         addr_in       = addr_ff + CW'(1);
         rd_act_in     = 1'b1;
         rd_idx_in     = addr_ff[AW-1:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_sid_in = req_data.replica_id;
               cur_pos_in = req_data.log_pos;
               res_in     = '0;
               addr_in    = '0;
               mark_in    = 1'b0;
               hit_in     = 1'b0;
               priority if (req_data.func == AQT_FUNC_CLEAR) begin
                  mem_ctl.clr = 1'b1;
                  state_in    = S_DONE;
               end else if (wait_count == AQT_WAIT_DIRECT) begin
                  res_in.quorum_reached = 1'b1;
                  res_in.quorum_pos     = req_data.log_pos;
                  res_in.quorum_server  = req_data.replica_id;
                  state_in              = S_DONE;
               end else if (req_data.replica_id == '0 || req_data.log_pos < last_pos_ff) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (rd_act_ff) begin
               if (rd_entry.server == '0) begin
                  mark_in     = 1'b1;
                  mark_idx_in = rd_idx_ff;
               end else if (rd_entry.server == cur_sid_ff && !hit_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  raise_in   = rd_entry.position < cur_pos_ff;
               end
            end
            if (scan_done) begin
               priority if (hit_ff) begin
                  mem_ctl.wr_en        = raise_ff;
                  mem_wr_addr          = hit_idx_ff;
                  mem_wr_data.server   = cur_sid_ff;
                  mem_wr_data.position = cur_pos_ff;
                  state_in             = S_DONE;
               end else if (mark_ff) begin
                  mem_ctl.wr_en        = 1'b1;
                  mem_wr_addr          = mark_idx_ff;
                  mem_wr_data.server   = cur_sid_ff;
                  mem_wr_data.position = cur_pos_ff;
                  state_in             = S_DONE;
               end else begin
                  addr_in    = '0;
                  min_pos_in = cur_pos_ff;
                  min_srv_in = cur_sid_ff;
                  state_in   = S_MIN;
               end
            end
         end
         S_MIN: begin
            if (rd_act_ff && rd_entry.server != '0 && rd_entry.position < min_pos_ff) begin
               min_pos_in = rd_entry.position;
               min_srv_in = rd_entry.server;
            end
            if (scan_done) begin
               last_pos_in = min_pos_ff;
               last_srv_in = min_srv_ff;
               addr_in     = '0;
               mark_in     = 1'b0;
               state_in    = S_FREE;
            end
         end
         S_FREE: begin
            if (rd_act_ff && rd_entry.position == last_pos_ff) begin
               mem_ctl.wr_en   = 1'b1;
               mem_ctl.wr_free = 1'b1;
               mem_wr_addr     = rd_idx_ff;
               mark_in         = 1'b1;
               mark_idx_in     = rd_idx_ff;
            end
            if (scan_done) begin
               mem_ctl.wr_en         = mark_ff && (cur_pos_ff > last_pos_ff);
               mem_wr_addr           = mark_idx_ff;
               mem_wr_data.server    = cur_sid_ff;
               mem_wr_data.position  = cur_pos_ff;
               res_in.quorum_reached = 1'b1;
               res_in.quorum_pos     = last_pos_ff;
               res_in.quorum_server  = last_srv_ff;
               state_in              = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign res_data = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         rd_act_ff   <= 1'b0;
         last_pos_ff <= '0;
         last_srv_ff <= '0;
      end else begin
         state_ff    <= state_in;
         rd_act_ff   <= rd_act_in;
         last_pos_ff <= last_pos_in;
         last_srv_ff <= last_srv_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_sid_ff  <= cur_sid_in;
      cur_pos_ff  <= cur_pos_in;
      addr_ff     <= addr_in;
      rd_idx_ff   <= rd_idx_in;
      mark_ff     <= mark_in;
      mark_idx_ff <= mark_idx_in;
      hit_ff      <= hit_in;
      hit_idx_ff  <= hit_idx_in;
      raise_ff    <= raise_in;
      min_pos_ff  <= min_pos_in;
      min_srv_ff  <= min_srv_in;
      res_ff      <= res_in;
   end

endmodule

@@ sv/aqt_checker.sv @@
// aqt_checker: port-level assertions for ack_quorum_tracker_core, bound below.
// Depends on aqt_pkg and the top level's port list.
module aqt_checker import aqt_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input req_type               req_data,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input rsp_type               rsp_data,
   input logic                  csr_wen,
   input logic [AQT_WAIT_W-1:0] csr_wdata
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");

   a_no_quorum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.quorum_reached |->
         rsp_data.quorum_pos == '0 && rsp_data.quorum_server == '0)
      else $error("nonzero payload without quorum");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind ack_quorum_tracker_core aqt_checker u_aqt_checker (.*);

@@ verif/ack_quorum_tracker_core_tb.sv @@
// ack_quorum_tracker_core_tb: self-checking testbench for the ack quorum tracker.
// Drives directed and random requests through valid/ready, predicts each result
// with its own model of the slot table, compares in order. Depends on aqt_pkg.
module ack_quorum_tracker_core_tb;
   import aqt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int SEG_ITEMS   = 78;
   localparam logic [AQT_POS_W-1:0] POS_CEIL = 64'hFFFF_FFFF_FFFF_FFE0;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_wen = 1'b0;
   logic [AQT_WAIT_W-1:0] csr_wdata = '0;

   ack_quorum_tracker_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_wdata (csr_wdata)
   );

   always #10 clock = ~clock;

   // predicted tracker state
   logic [AQT_WAIT_W-1:0] wait_cnt = AQT_WAIT_RESET;
   logic [AQT_SID_W-1:0]  slot_sid [AQT_SLOTS];
   logic [AQT_POS_W-1:0]  slot_pos [AQT_SLOTS];
   logic [AQT_POS_W-1:0]  rep_pos = '0;
   logic [AQT_SID_W-1:0]  rep_sid = '0;

   req_type req_q[$];
   rsp_type quorum_expect_q[$];
   int      open_reqs = 0;
   int      err_count = 0;
   int      send_idle_pct = 0;
   int      recv_idle_pct = 0;
   int      stall_cycles = 0;
   logic [AQT_POS_W-1:0] pos_base = 64'd100;

   function automatic void clear_table();
      for (int i = 0; i < AQT_SLOTS; i++) begin
         slot_sid[i] = '0;
         slot_pos[i] = '0;
      end
   endfunction

   function automatic int active_slot_count();
      int n;
      n = (wait_cnt == AQT_WAIT_NONE) ? 0 : int'(wait_cnt) - 1;
      return (n > AQT_SLOTS) ? AQT_SLOTS : n;
   endfunction

   function automatic rsp_type predict_quorum(req_type r);
      rsp_type res;
      int      n;
      int      free_idx;
      int      min_idx;
      logic    done;
      logic    have_min;
      logic [AQT_POS_W-1:0] min_val;
      res = '0;
      n = active_slot_count();
      if (r.func == AQT_FUNC_CLEAR) begin
         clear_table();
      end else if (wait_cnt == AQT_WAIT_DIRECT) begin
         res.quorum_reached = 1'b1;
         res.quorum_pos     = r.log_pos;
         res.quorum_server  = r.replica_id;
      end else if (r.replica_id != '0 && r.log_pos >= rep_pos) begin
         free_idx = n;
         done = 1'b0;
         for (int i = 0; i < n; i++) begin
            if (!done) begin
               if (slot_sid[i] == '0) begin
                  free_idx = i;
               end else if (slot_sid[i] == r.replica_id) begin
                  if (slot_pos[i] < r.log_pos) slot_pos[i] = r.log_pos;
                  done = 1'b1;
               end
            end
         end
         if (!done && free_idx < n) begin
            slot_sid[free_idx] = r.replica_id;
            slot_pos[free_idx] = r.log_pos;
            done = 1'b1;
         end
         if (!done) begin
            // table full: report the lowest position under the new one
            have_min = 1'b0;
            min_idx  = 0;
            min_val  = r.log_pos;
            for (int i = 0; i < n; i++) begin
               if (slot_sid[i] != '0 && slot_pos[i] < min_val) begin
                  min_val  = slot_pos[i];
                  min_idx  = i;
                  have_min = 1'b1;
               end
            end
            if (have_min) begin
               rep_sid = slot_sid[min_idx];
               rep_pos = slot_pos[min_idx];
            end else begin
               rep_sid = r.replica_id;
               rep_pos = r.log_pos;
            end
            free_idx = n;
            for (int i = 0; i < n; i++) begin
               if (slot_pos[i] == rep_pos) begin
                  slot_sid[i] = '0;
                  slot_pos[i] = '0;
                  free_idx = i;
               end
            end
            if (r.log_pos > rep_pos && free_idx < n) begin
               slot_sid[free_idx] = r.replica_id;
               slot_pos[free_idx] = r.log_pos;
            end
            res.quorum_reached = 1'b1;
            res.quorum_pos     = rep_pos;
            res.quorum_server  = rep_sid;
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(string msg);
      err_count++;
      if (err_count <= 10) $display("mismatch: %s", msg);
   endtask

   // request driver
   always @(posedge clock) begin
      logic holding;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         holding = req_valid && !req_ready;
         if (req_valid && req_ready) quorum_expect_q.push_back(predict_quorum(req_data));
         if (!holding) begin
            if (req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_data  <= req_q.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            open_reqs--;
            if (quorum_expect_q.size() == 0) begin
               note_mismatch($sformatf("unexpected result reached=%0b pos=%h server=%h",
                  rsp_data.quorum_reached, rsp_data.quorum_pos, rsp_data.quorum_server));
            end else begin
               want = quorum_expect_q.pop_front();
               if (rsp_data.quorum_reached !== want.quorum_reached ||
                   rsp_data.quorum_pos !== want.quorum_pos ||
                   rsp_data.quorum_server !== want.quorum_server) begin
                  note_mismatch($sformatf(
                     "exp reached=%0b pos=%h server=%h got reached=%0b pos=%h server=%h",
                     want.quorum_reached, want.quorum_pos, want.quorum_server,
                     rsp_data.quorum_reached, rsp_data.quorum_pos,
                     rsp_data.quorum_server));
               end
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog: no progress on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic push_req(req_type r);
      req_q.push_back(r);
      open_reqs++;
   endtask

   task automatic wait_idle();
      while (open_reqs != 0) @(posedge clock);
   endtask

   task automatic write_wait_count(logic [AQT_WAIT_W-1:0] v);
      wait_idle();
      repeat (4) @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen <= 1'b0;
      if (v != AQT_WAIT_NONE) begin
         wait_cnt = v;
         clear_table();
      end
   endtask

   function automatic req_type make_ack(int n);
      req_type r;
      int      roll;
      roll = $urandom_range(0, 99);
      r.func = (roll < 4) ? AQT_FUNC_CLEAR : AQT_FUNC_ACK;
      if (n == 0) begin
         r.replica_id = $urandom();
         r.log_pos    = {$urandom(), $urandom()};
         return r;
      end
      r.replica_id = $urandom_range(1, n + 2);
      if (roll >= 4 && roll < 9) r.replica_id = $urandom();
      else if (roll == 9) r.replica_id = '0;
      if (pos_base < POS_CEIL) pos_base += $urandom_range(0, 6);
      r.log_pos = pos_base + $urandom_range(0, 12);
      if (roll >= 10 && roll < 18) r.log_pos = pos_base - $urandom_range(1, 60);
      return r;
   endfunction

   logic [AQT_WAIT_W-1:0] seg_wait [12] =
      '{4'd2, 4'd9, 4'd1, 4'd4, 4'd15, 4'd0, 4'd3, 4'd1, 4'd6, 4'd10, 4'd5, 4'd8};

   initial begin
      clear_table();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 32;
      recv_idle_pct = 76;

      // direct mode after reset
      push_req(req_type'{AQT_FUNC_ACK, 32'd1, 64'd0});
      push_req(req_type'{AQT_FUNC_ACK, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
      push_req(req_type'{AQT_FUNC_ACK, 32'd0, 64'h8000_0000_0000_0001});
      push_req(req_type'{AQT_FUNC_CLEAR, 32'd5, 64'd7});

      // two-slot table: fill, raise, quorum on new, quorum on stored, stale, tie
      write_wait_count(4'd3);
      push_req(req_type'{AQT_FUNC_ACK, 32'd1, 64'd10});
      push_req(req_type'{AQT_FUNC_ACK, 32'd2, 64'd20});
      push_req(req_type'{AQT_FUNC_ACK, 32'd1, 64'd15});
      push_req(req_type'{AQT_FUNC_ACK, 32'd1, 64'd12});
      push_req(req_type'{AQT_FUNC_ACK, 32'd3, 64'd12});
      push_req(req_type'{AQT_FUNC_ACK, 32'd4, 64'd30});
      push_req(req_type'{AQT_FUNC_ACK, 32'd5, 64'd5});
      push_req(req_type'{AQT_FUNC_ACK, 32'd0, 64'd40});
      push_req(req_type'{AQT_FUNC_CLEAR, 32'd0, 64'd0});
      push_req(req_type'{AQT_FUNC_ACK, 32'd6, 64'd40});
      push_req(req_type'{AQT_FUNC_ACK, 32'd7, 64'd40});
      push_req(req_type'{AQT_FUNC_ACK, 32'd8, 64'd40});
      push_req(req_type'{AQT_FUNC_ACK, 32'd6, 64'd41});

      // zero write is dropped, table keeps its entry
      write_wait_count(AQT_WAIT_NONE);
      push_req(req_type'{AQT_FUNC_ACK, 32'd9, 64'd50});
      push_req(req_type'{AQT_FUNC_ACK, 32'd6, 64'd45});

      for (int s = 0; s < 12; s++) begin
         write_wait_count(seg_wait[s]);
         if (s == 4) begin
            send_idle_pct = 76;
            recv_idle_pct = 32;
         end else if (s == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (s == 11) pos_base = 64'hFFFF_FFFF_FFFF_FC00;
         repeat (SEG_ITEMS) push_req(make_ack(active_slot_count()));
      end

      wait_idle();
      repeat (40) @(posedge clock);
      if (err_count == 0 && quorum_expect_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
